FILE: rtl/wntf_pkg.sv
// Package for the wildcard name/type filter.
// Holds op codes, filter codes, character constants and the structs between
// the top level and the match core. No dependencies.
package wntf_pkg;

  localparam int MaxPatternDef = 64;

  localparam int OpW     = 2;
  localparam int CharW   = 8;
  localparam int KindW   = 2;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 2;

  typedef enum logic [OpW-1:0] {
    OpAppend   = 2'd0,
    OpClear    = 2'd1,
    OpNameChar = 2'd2,
    OpNameEnd  = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNameFilterEn = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTypeFilter   = 1'd1;

  // Type filter codes
  localparam logic [1:0] TypeAny     = 2'd0;
  localparam logic [1:0] TypeRegular = 2'd1;
  localparam logic [1:0] TypeDir     = 2'd2;

  // Entry kinds
  localparam logic [KindW-1:0] KindRegular = 2'd0;
  localparam logic [KindW-1:0] KindDir     = 2'd1;

  localparam logic [CharW-1:0] CharStar     = 8'h2A;
  localparam logic [CharW-1:0] CharQuestion = 8'h3F;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [CharW-1:0] character;
  } match_cmd_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_status_t;

endpackage

FILE: rtl/wntf_item_if.sv
// Input item channel: valid/ready plus op, character and entry kind.
// Depends on wntf_pkg for field widths.
interface wntf_item_if;
  logic                      valid;
  logic                      ready;
  logic [wntf_pkg::OpW-1:0]   op;
  logic [wntf_pkg::CharW-1:0] character;
  logic [wntf_pkg::KindW-1:0] entry_kind;

  modport source (output valid, op, character, entry_kind, input ready);
  modport sink   (input valid, op, character, entry_kind, output ready);
endinterface

FILE: rtl/wntf_result_if.sv
// Result channel: valid/ready plus accepted and pattern_overflow.
// No dependencies.
interface wntf_result_if;
  logic valid;
  logic ready;
  logic accepted;
  logic pattern_overflow;

  modport source (output valid, accepted, pattern_overflow, input ready);
  modport sink   (input valid, accepted, pattern_overflow, output ready);
endinterface

FILE: rtl/wntf_cfg_if.sv
// Configuration write channel: valid/ready plus register index and data.
// Depends on wntf_pkg for field widths.
interface wntf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wntf_pkg::CfgIdxW-1:0]  index;
  logic [wntf_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/wildcard_name_type_filter_unit.sv
// Wildcard name and entry type filter, top level.
// Depends on wntf_pkg, the three channel interfaces and wntf_match.
//
// Usage:
//   in_i carries one word per cycle when ready: pattern bytes (append), pattern clear,
//   name bytes, and a name-end word that carries the entry kind. Pattern
//   edits restart the name under way. '*' matches any run of bytes, '?'
//   exactly one byte.
//   out_o carries one word per name end: accepted and pattern_overflow.
//   cfg_i writes name_filter_enable (index 0) and type_filter (index 1);
//   it is always ready; the user must write it only while the block is idle (not enforced).
// Timing:
//   One input word per cycle while in_i.ready is high. A name-end word shows its
//   result on out_o in the next cycle; the active-position update, including the star
//   closure done as one carry chain over the pattern, completes in that cycle.
//   in_i.ready drops only while a result sits in the output register and
//   out_o.ready is low; a result that is taken frees the slot the same cycle.
// Reset:
//   Pattern empty, overflow clear, filters off, output empty. The pattern
//   store contents are not cleared; only the first pattern-length bytes
//   are ever read.
module wildcard_name_type_filter_unit #(
  parameter int MaxPattern = wntf_pkg::MaxPatternDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wntf_item_if.sink     in_i,
  wntf_result_if.source out_o,
  wntf_cfg_if.sink      cfg_i
);

  logic       name_en_q;
  logic [1:0] type_filter_q;

  logic out_valid_q;
  logic out_accepted_q;
  logic out_ovf_q;

  logic                    in_fire;
  wntf_pkg::op_e           op;
  wntf_pkg::match_cmd_t    cmd;
  wntf_pkg::match_status_t status;
  logic                    kind_ok;
  logic                    accepted;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign op          = wntf_pkg::op_e'(in_i.op);
  assign cfg_i.ready = 1'b1;

  assign cmd.valid     = in_fire;
  assign cmd.op        = op;
  assign cmd.character = in_i.character;

  wntf_match #(
    .MaxPattern(MaxPattern)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .status_o(status)
  );

  always_comb begin
    case (type_filter_q)
      wntf_pkg::TypeRegular: kind_ok = (in_i.entry_kind == wntf_pkg::KindRegular);
      wntf_pkg::TypeDir:     kind_ok = (in_i.entry_kind == wntf_pkg::KindDir);
      default:               kind_ok = 1'b1;
    endcase
  end

  assign accepted = !status.overflow && (!name_en_q || status.matched) && kind_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_en_q     <= 1'b0;
      type_filter_q <= wntf_pkg::TypeAny;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        wntf_pkg::CfgNameFilterEn: name_en_q     <= cfg_i.data[0];
        wntf_pkg::CfgTypeFilter:   type_filter_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && op == wntf_pkg::OpNameEnd) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on name end only.
  always_ff @(posedge clk_i) begin
    if (in_fire && op == wntf_pkg::OpNameEnd) begin
      out_accepted_q <= accepted;
      out_ovf_q      <= status.overflow;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.accepted         = out_accepted_q;
  assign out_o.pattern_overflow = out_ovf_q;

endmodule

FILE: rtl/wntf_match.sv
// Glob match core: pattern store, pattern length, overflow flag and the
// bit-parallel set of active pattern positions. Depends on wntf_pkg.
module wntf_match #(
  parameter int MaxPattern = wntf_pkg::MaxPatternDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wntf_pkg::match_cmd_t    cmd_i,
  output wntf_pkg::match_status_t status_o
);

  localparam int NPos = MaxPattern + 1;
  localparam int LenW = $clog2(MaxPattern + 1);

  logic [wntf_pkg::CharW-1:0] store_q [MaxPattern];
  logic [LenW-1:0]            len_q, len_d;
  logic                       ovf_q, ovf_d;
  logic [NPos-1:0]            active_q, active_d;

  logic [NPos-1:0] star;
  logic [NPos-1:0] step;     // non-star position i that consumes the byte
  logic [NPos-1:0] seed;
  logic [NPos:0]   sum;
  logic [NPos-1:0] carry;
  logic [NPos-1:0] closed;
  logic [NPos-1:0] nxt;
  logic            room;

  assign room = (len_q != LenW'(MaxPattern));

  // Per-position decode of the stored pattern.
  for (genvar i = 0; i < MaxPattern; i++) begin : g_pos
    logic in_use;
    logic is_star;
    logic hit;
    assign in_use  = (LenW'(i) < len_q);
    assign is_star = (store_q[i] == wntf_pkg::CharStar);
    assign hit     = (store_q[i] == wntf_pkg::CharQuestion) ||
                     (store_q[i] == cmd_i.character);
    assign star[i] = in_use && is_star;
    assign step[i] = in_use && !is_star && hit;

    always_ff @(posedge clk_i) begin
      if (cmd_i.valid && cmd_i.op == wntf_pkg::OpAppend && room &&
          len_q == LenW'(i)) begin
        store_q[i] <= cmd_i.character;
      end
    end
  end
  assign star[NPos-1] = 1'b0;
  assign step[NPos-1] = 1'b0;

  // Star closure as a carry chain: active stars generate, stars propagate.
  assign seed   = active_q & star;
  assign sum    = {1'b0, star} + {1'b0, seed};
  assign carry  = sum[NPos-1:0] ^ star ^ seed;
  assign closed = active_q | carry;

  // Star positions hold, other positions advance on a match.
  assign nxt = (closed & star) | {(closed[NPos-2:0] & step[NPos-2:0]), 1'b0};

  always_comb begin
    len_d    = len_q;
    ovf_d    = ovf_q;
    active_d = active_q;
    if (cmd_i.valid) begin
      case (cmd_i.op)
        wntf_pkg::OpAppend: begin
          if (room) begin
            len_d = len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          active_d = NPos'(1);
        end
        wntf_pkg::OpClear: begin
          len_d    = '0;
          ovf_d    = 1'b0;
          active_d = NPos'(1);
        end
        wntf_pkg::OpNameChar: begin
          active_d = nxt;
        end
        default: begin
          active_d = NPos'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      active_q <= NPos'(1);
    end else begin
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      active_q <= active_d;
    end
  end

  assign status_o.matched  = closed[len_q];
  assign status_o.overflow = ovf_q;

endmodule

FILE: rtl/wntf_checker.sv
// Port-level checks for the wildcard name/type filter.
// Depends on wntf_pkg; bound to wildcard_name_type_filter_unit below.
module wntf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [wntf_pkg::OpW-1:0]   in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_accepted,
  input logic                       out_overflow,
  input logic                       cfg_ready
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
    $stable(out_overflow))
    else $error("stalled result changed");

  // Overflow forces no-match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_accepted && out_overflow))
    else $error("accepted with overflow");

  // A name end taken shows a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op == wntf_pkg::OpNameEnd |=> out_valid)
    else $error("name end lost");

  // Input only waits on a full output slot that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind wildcard_name_type_filter_unit wntf_checker u_wntf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_op       (in_i.op),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_accepted(out_o.accepted),
  .out_overflow(out_o.pattern_overflow),
  .cfg_ready   (cfg_i.ready)
);

FILE: dv/tb.sv
// Testbench for wildcard_name_type_filter_unit: glob pattern load, name streaming
// and type filtering, checked against an in-bench match predictor.
// Depends on wntf_pkg and the item, result and config channel interfaces.
`timescale 1ns / 1ps

module tb;
  import wntf_pkg::*;

  localparam int PatDepth = MaxPatternDef;
  localparam int PhaseWords = 165;
  localparam int HoldCycles = 200;
  localparam int CycleLimit = 200000;
  localparam int DrainLimit = 2000;
  localparam logic [PatDepth:0] StartPos = 1;
  localparam logic [7:0] LetterA = 8'h61;
  localparam logic [7:0] PhaseEnable = 8'b1011_0110;
  localparam logic [15:0] PhaseType = 16'b01_10_00_11_11_10_01_00;

  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;
    logic [KindW-1:0] kind;
  } filter_word_t;

  typedef struct packed {
    logic accepted;
    logic overflow;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wntf_item_if   in_if ();
  wntf_result_if out_if ();
  wntf_cfg_if    cfg_if ();

  wildcard_name_type_filter_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  filter_word_t pending_words[$];
  verdict_t     expected_verdicts[$];
  int unsigned  err_count = 0;
  int unsigned  phase_words;
  int unsigned  cycle_cnt;
  logic [7:0]   gen_pattern[$];

  // ---------------------------------------------------------------------------
  // Match predictor
  // ---------------------------------------------------------------------------
  logic [7:0]        mirror_pattern[PatDepth];
  int                mirror_len;
  logic              mirror_overflow;
  logic [PatDepth:0] live_positions;
  logic              filter_en;
  logic [1:0]        type_sel;

  function automatic logic [PatDepth:0] star_closed(input logic [PatDepth:0] pos);
    logic [PatDepth:0] s;
    s = pos;
    for (int i = 0; i < PatDepth; i++)
      if (i < mirror_len && s[i] && mirror_pattern[i] == CharStar) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic logic kind_passes(input logic [KindW-1:0] kind);
    case (type_sel)
      TypeRegular: return kind == KindRegular;
      TypeDir:     return kind == KindDir;
      default:     return 1'b1;
    endcase
  endfunction

  function automatic void predict_word(input op_e op, input logic [7:0] ch,
                                       input logic [KindW-1:0] kind);
    logic [PatDepth:0] cur;
    logic [PatDepth:0] nxt;
    verdict_t v;
    case (op)
      OpAppend: begin
        if (mirror_len < PatDepth) begin
          mirror_pattern[mirror_len] = ch;
          mirror_len++;
        end else begin
          mirror_overflow = 1'b1;
        end
        live_positions = StartPos;
      end
      OpClear: begin
        mirror_len = 0;
        mirror_overflow = 1'b0;
        live_positions = StartPos;
      end
      OpNameChar: begin
        cur = star_closed(live_positions);
        nxt = '0;
        for (int i = 0; i < PatDepth; i++) begin
          if (i < mirror_len && cur[i]) begin
            if (mirror_pattern[i] == CharStar) nxt[i] = 1'b1;
            else if (mirror_pattern[i] == CharQuestion || mirror_pattern[i] == ch)
              nxt[i+1] = 1'b1;
          end
        end
        live_positions = nxt;
      end
      default: begin
        cur = star_closed(live_positions);
        if (mirror_overflow) begin
          v.accepted = 1'b0;
          v.overflow = 1'b1;
        end else begin
          v.accepted = (!filter_en || cur[mirror_len]) && kind_passes(kind);
          v.overflow = 1'b0;
        end
        expected_verdicts.push_back(v);
        live_positions = StartPos;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: config mirror, result check, then prediction for this edge
  // ---------------------------------------------------------------------------
  verdict_t got_verdict;
  verdict_t want_verdict;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mirror_len = 0;
      mirror_overflow = 1'b0;
      live_positions = StartPos;
      filter_en = 1'b0;
      type_sel = TypeAny;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgNameFilterEn: filter_en = cfg_if.data[0];
          CfgTypeFilter:   type_sel = cfg_if.data;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got_verdict.accepted = out_if.accepted;
        got_verdict.overflow = out_if.pattern_overflow;
        if (expected_verdicts.size() == 0) begin
          $error("result word with no expectation pending: accepted=%0b overflow=%0b",
                 got_verdict.accepted, got_verdict.overflow);
          err_count++;
        end else begin
          want_verdict = expected_verdicts.pop_front();
          if (got_verdict.accepted !== want_verdict.accepted) begin
            $error("accepted: expected %0b, got %0b",
                   want_verdict.accepted, got_verdict.accepted);
            err_count++;
          end
          if (got_verdict.overflow !== want_verdict.overflow) begin
            $error("pattern_overflow: expected %0b, got %0b",
                   want_verdict.overflow, got_verdict.overflow);
            err_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        predict_word(op_e'(in_if.op), in_if.character, in_if.entry_kind);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: pops pending words, random gap after each one
  // ---------------------------------------------------------------------------
  filter_word_t next_word;
  int unsigned  src_gap;
  logic         src_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.op         <= OpAppend;
      in_if.character  <= '0;
      in_if.entry_kind <= '0;
      src_gap          <= 0;
      src_burst        <= 1'b0;
    end else begin
      if ($urandom_range(0, 47) == 0) src_burst <= !src_burst;
      // hold the word until it is taken
      if (!in_if.valid || in_if.ready) begin
        if (src_gap != 0) begin
          in_if.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_if.valid      <= 1'b1;
          in_if.op         <= next_word.op;
          in_if.character  <= next_word.ch;
          in_if.entry_kind <= next_word.kind;
          src_gap <= src_burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall per result, two long hold-offs to back up the input
  // ---------------------------------------------------------------------------
  int unsigned snk_stall;
  int unsigned snk_hold;
  int unsigned stall_draw;
  int unsigned taken_cnt;
  logic        snk_burst;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_stall    <= 0;
      snk_hold     <= 0;
      taken_cnt    <= 0;
      snk_burst    <= 1'b0;
    end else begin
      if ($urandom_range(0, 47) == 0) snk_burst <= !snk_burst;
      if (out_if.valid && out_if.ready) taken_cnt <= taken_cnt + 1;
      if (snk_hold != 0) begin
        out_if.ready <= 1'b0;
        snk_hold <= snk_hold - 1;
      end else if (out_if.valid && out_if.ready && (taken_cnt == 40 || taken_cnt == 600)) begin
        out_if.ready <= 1'b0;
        snk_hold <= HoldCycles;
      end else if (out_if.valid && out_if.ready) begin
        stall_draw = snk_burst ? 0 : $urandom_range(0, 3);
        out_if.ready <= (stall_draw == 0);
        snk_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
      end else if (snk_stall != 0) begin
        out_if.ready <= 1'b0;
        snk_stall <= snk_stall - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_word(input op_e op, input logic [7:0] ch,
                                     input logic [KindW-1:0] kind);
    filter_word_t w;
    w.op = op;
    w.ch = ch;
    w.kind = kind;
    pending_words.push_back(w);
    phase_words++;
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return LetterA + 8'($urandom_range(0, 2));
    if (r < 6) return CharStar;
    if (r < 8) return CharQuestion;
    if (r == 8) return 8'($urandom_range(0, 255));
    return LetterA;
  endfunction

  function automatic logic [7:0] pick_name_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return LetterA + 8'($urandom_range(0, 2));
    if (r == 7) return $urandom_range(0, 1) ? CharStar : CharQuestion;
    return 8'($urandom_range(0, 255));
  endfunction

  // One random sequence: mostly a name, at times after a new pattern load, that
  // usually fits or nearly fits the pattern; the rest loose words in any order.
  function automatic void add_sequence();
    int unsigned n_chars;
    logic [7:0]  c;
    logic [7:0]  name_bytes[$];
    int unsigned pick;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 2) == 0) begin
        queue_word(OpClear, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
        gen_pattern.delete();
        n_chars = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 6);
        repeat (n_chars) begin
          c = pick_pattern_char();
          queue_word(OpAppend, c, 2'($urandom_range(0, 3)));
          if (gen_pattern.size() < PatDepth) gen_pattern.push_back(c);
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        foreach (gen_pattern[i]) begin
          if (gen_pattern[i] == CharStar)
            repeat ($urandom_range(0, 3)) name_bytes.push_back(pick_name_char());
          else if (gen_pattern[i] == CharQuestion)
            name_bytes.push_back(pick_name_char());
          else
            name_bytes.push_back(gen_pattern[i]);
        end
        // near misses: swap one byte or drop the last one
        if ($urandom_range(0, 3) == 0 && name_bytes.size() != 0) begin
          if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, name_bytes.size() - 1);
            name_bytes[pick] = pick_name_char();
          end else begin
            void'(name_bytes.pop_back());
          end
        end
      end else begin
        repeat ($urandom_range(0, 6)) name_bytes.push_back(pick_name_char());
      end
      foreach (name_bytes[i]) queue_word(OpNameChar, name_bytes[i], 2'($urandom_range(0, 3)));
      queue_word(OpNameEnd, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        c = 8'($urandom_range(0, 255));
        queue_word(op_e'($urandom_range(0, 3)), c, 2'($urandom_range(0, 3)));
        if (gen_pattern.size() < PatDepth && pending_words[$].op == OpAppend)
          gen_pattern.push_back(c);
        if (pending_words[$].op == OpClear) gen_pattern.delete();
      end
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every word is taken and every result is in, then let the
  // pipeline settle past words that give no result. Sample between edges so
  // the driver and monitor updates of the last edge are already visible.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_if.valid || expected_verdicts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------------
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned drain;
    in_if.valid      = 1'b0;
    in_if.op         = OpAppend;
    in_if.character  = '0;
    in_if.entry_kind = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CfgNameFilterEn;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    write_reg(CfgNameFilterEn, 2'b11);
    write_reg(CfgTypeFilter, TypeAny);
    @(negedge clk_i);

    // empty pattern: empty name matches, any other name does not
    queue_word(OpNameEnd, 8'hFF, KindRegular);
    queue_word(OpNameChar, 8'h00, 2'd0);
    queue_word(OpNameEnd, 8'h00, 2'd3);
    // question mark never matches past the end of the name
    queue_word(OpAppend, LetterA, 2'd3);
    queue_word(OpAppend, CharQuestion, 2'd0);
    queue_word(OpNameChar, LetterA, 2'd0);
    queue_word(OpNameEnd, 8'hFF, KindDir);
    queue_word(OpNameChar, LetterA, 2'd0);
    queue_word(OpNameChar, 8'hFF, 2'd0);
    queue_word(OpNameEnd, 8'h00, 2'd2);
    // pattern edit mid-name restarts the name
    queue_word(OpNameChar, LetterA + 8'd2, 2'd0);
    queue_word(OpAppend, CharStar, 2'd0);
    queue_word(OpNameChar, LetterA, 2'd0);
    queue_word(OpNameChar, LetterA + 8'd1, 2'd0);
    queue_word(OpNameChar, LetterA + 8'd2, 2'd0);
    queue_word(OpNameEnd, 8'h55, KindRegular);
    queue_word(OpClear, 8'hFF, 2'd3);
    queue_word(OpNameEnd, 8'hAA, KindRegular);
    // fill the store exactly, then one byte past it
    repeat (PatDepth) queue_word(OpAppend, CharStar, 2'd0);
    queue_word(OpNameChar, LetterA, 2'd0);
    queue_word(OpNameEnd, 8'h00, KindRegular);
    queue_word(OpAppend, LetterA, 2'd0);
    queue_word(OpNameEnd, 8'h00, KindRegular);
    queue_word(OpClear, 8'h00, 2'd0);
    queue_word(OpNameChar, LetterA, 2'd0);
    queue_word(OpNameEnd, 8'h00, KindRegular);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_reg(CfgNameFilterEn, {1'($urandom_range(0, 1)), PhaseEnable[p]});
      write_reg(CfgTypeFilter, PhaseType[2*p +: 2]);
      @(negedge clk_i);
      phase_words = 0;
      while (phase_words < PhaseWords) add_sequence();
      wait_idle();
    end

    drain = 0;
    while (expected_verdicts.size() != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", expected_verdicts.size());
      err_count++;
    end
    repeat (10) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
